@@ sv/prfl_pkg.sv @@
// ----------------------------------------------------------------------------
// prfl_pkg
// Shared types and codes of the paging frame manager.
// ----------------------------------------------------------------------------
`default_nettype none
package prfl_pkg;

    // command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    // result status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_FAULT    = 3'd1;
    localparam logic [2:0] ST_EVICT    = 3'd2;
    localparam logic [2:0] ST_SEGFAULT = 3'd3;
    localparam logic [2:0] ST_BAD_PID  = 3'd4;
    localparam logic [2:0] ST_DEAD     = 3'd5;
    localparam logic [2:0] ST_RECORDED = 3'd6;

    // configuration register indexes
    localparam logic CFG_ALGORITHM = 1'b0;
    localparam logic CFG_PROC_CNT  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  pid;
        logic [15:0] address;
        logic [15:0] process_size;
    } prfl_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  frame;
        logic [3:0]  evict_pid;
        logic [3:0]  victim_page;
        logic [31:0] time_stamp;
    } prfl_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_KILL,
        S_WRITE
    } prfl_state_t;

endpackage
`default_nettype wire

@@ sv/page_replacement_fifo_lru.sv @@
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Demand-paging frame manager with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A record command or
// a command with a bad pid gives its result on done in the next cycle and
// leaves busy low, so such a command can be taken every cycle. An access
// raises busy: its pid is checked as it is taken, S_DIV checks for a dead
// process and the size and forms the page number, S_SCAN scans the frame
// table (one read a cycle, reads registered), and S_WRITE writes the entry
// back on a miss or under LRU. The result shows on done in the cycle busy
// drops, and no new command is taken before then. An access of a dead
// process ends in S_DIV; a segfault sweeps the table in S_KILL to free the
// frames of the process. The result is valid only in the cycle done is high
// and cannot be held off.
`default_nettype none
module page_replacement_fifo_lru
    import prfl_pkg::*;
#(
    parameter int FRAME_CNT  = 7,
    parameter int PAGE_BYTES = 3000,
    parameter int MAX_PROCS  = 8,
    parameter int MAX_PAGES  = 16
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire prfl_in_t  in_item,
    output logic           done,
    output prfl_out_t      result,
    input  wire logic      cfg_we,
    input  wire logic      cfg_index,
    input  wire logic [3:0] cfg_data
);

    localparam int FW = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
    localparam int FC = $clog2(FRAME_CNT + 1);
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int GW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam logic [31:0] CAP32 = 32'(MAX_PAGES) * 32'(PAGE_BYTES);
    localparam logic [16:0] CAP = (CAP32 > 32'd65535) ? 17'h1_0000 : CAP32[16:0];

    // frame table entry kept in one memory
    typedef struct packed {
        logic [3:0]  owner;
        logic [GW-1:0] page;
        logic [31:0] load_t;
        logic [31:0] use_t;
    } fent_t;

    fent_t        fmem [FRAME_CNT];
    fent_t        frd_reg;
    logic [FRAME_CNT-1:0] fown_reg;   // owned bit per frame (reset as free)

    logic [15:0]  psize [MAX_PROCS];
    logic [MAX_PROCS-1:0] pdead_reg;
    logic [MAX_PROCS-1:0] pvalid_reg;

    logic         alg_reg;
    logic [3:0]   pcnt_reg;
    logic [31:0]  time_reg, time_next;

    prfl_state_t  state_reg, state_next;
    prfl_in_t     item_reg;
    logic [31:0]  now_reg;
    logic [GW-1:0] page_reg;
    logic [FC-1:0] idx_reg;      // frame being read
    logic         rd_v_reg;      // frd_reg holds a valid read
    logic [FW-1:0] rd_f_reg;
    logic         hit_reg, free_reg;
    logic [FW-1:0] hit_f_reg, free_f_reg, vic_f_reg;
    logic [31:0]  hit_ld_reg;
    logic [31:0]  best_reg;
    logic [3:0]   vpid_reg;
    logic [GW-1:0] vpage_reg;
    logic [15:0]  psz_reg;

    logic [3:0]   live;
    logic         pid_ok;
    logic [PW-1:0] pidx;
    logic [15:0]  psz_cur;
    logic [GW-1:0] page_calc;
    logic         done_next;

    logic         fm_re, fm_we;
    logic [FW-1:0] fm_raddr, fm_waddr;
    fent_t        fm_wdata;
    logic         ps_we;
    logic [PW-1:0] ps_addr;
    logic [15:0]  ps_wdata;

    assign live    = (pcnt_reg > 4'(MAX_PROCS)) ? 4'(MAX_PROCS) : pcnt_reg;
    assign pid_ok  = (in_item.pid != 8'd0) && (in_item.pid <= {4'd0, live});
    assign pidx    = PW'(item_reg.pid - 8'd1);
    assign psz_cur = pvalid_reg[pidx] ? psz_reg : 16'd0;
    assign busy    = (state_reg != S_IDLE);

    // page number by compare against page boundaries
    always_comb
    begin
        page_calc = '0;
        for (int k = 1; k < MAX_PAGES; k++)
        begin
            if (32'(item_reg.address) >= 32'(k) * 32'(PAGE_BYTES))
                page_calc = GW'(k);
        end
    end

    // frame table port controls
    assign fm_re    = (state_reg == S_SCAN || state_reg == S_KILL) &&
                      (32'(idx_reg) < 32'(FRAME_CNT));
    assign fm_raddr = FW'(idx_reg);
    assign fm_waddr = hit_reg ? hit_f_reg : (free_reg ? free_f_reg : vic_f_reg);
    assign fm_we    = (state_reg == S_WRITE) && (!hit_reg || alg_reg);
    assign fm_wdata = '{owner: item_reg.pid[3:0], page: page_reg,
                        load_t: hit_reg ? hit_ld_reg : now_reg, use_t: now_reg};

    // process size port controls
    assign ps_addr  = PW'(in_item.pid - 8'd1);
    assign ps_we    = (state_reg == S_IDLE) && start && pid_ok &&
                      (in_item.command == CMD_RECORD);
    assign ps_wdata = ({1'b0, in_item.process_size} > CAP) ? CAP[15:0]
                                                           : in_item.process_size;

    // frame table memory
    always_ff @(posedge clk)
    begin
        if (fm_we)
            fmem[fm_waddr] <= fm_wdata;
        if (fm_re)
            frd_reg <= fmem[fm_raddr];
    end

    // process size memory
    always_ff @(posedge clk)
    begin
        if (ps_we)
            psize[ps_addr] <= ps_wdata;
        if (state_reg == S_IDLE && start)
            psz_reg <= psize[ps_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg  <= 1'b0;
            pcnt_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALGORITHM: alg_reg  <= cfg_data[0];
                CFG_PROC_CNT:  pcnt_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start && pid_ok && in_item.command == CMD_ACCESS)
                         state_next = S_DIV;
            S_DIV:   if (pdead_reg[pidx])
                         state_next = S_IDLE;
                     else if (item_reg.address >= psz_cur)
                         state_next = S_KILL;
                     else
                         state_next = S_SCAN;
            S_SCAN:  if (rd_v_reg && 32'(rd_f_reg) == 32'(FRAME_CNT - 1))
                         state_next = S_WRITE;
            S_KILL:  if (32'(idx_reg) == 32'(FRAME_CNT))
                         state_next = S_IDLE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // result strobe
    always_comb
    begin
        done_next = 1'b0;
        unique case (state_reg)
            S_IDLE:  done_next = start && (!pid_ok || in_item.command == CMD_RECORD);
            S_DIV:   done_next = pdead_reg[pidx];
            S_SCAN:  done_next = 1'b0;
            S_KILL:  done_next = (32'(idx_reg) == 32'(FRAME_CNT));
            S_WRITE: done_next = 1'b1;
            default: done_next = 1'b0;
        endcase
    end

    assign time_next = time_reg + 32'd1;

    // main datapath and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            time_reg   <= 32'd0;
            fown_reg   <= '0;
            pdead_reg  <= '0;
            pvalid_reg <= '0;
            done       <= 1'b0;
            rd_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= in_item;
                        now_reg  <= time_reg;
                        result   <= '{status: (pid_ok && in_item.command == CMD_RECORD)
                                              ? ST_RECORDED : ST_BAD_PID,
                                      frame: 3'd0, evict_pid: 4'd0,
                                      victim_page: 4'd0, time_stamp: time_reg};
                        if (!pid_ok)
                        begin
                            if (in_item.command == CMD_ACCESS)
                                time_reg <= time_next;
                        end
                        else if (in_item.command == CMD_RECORD)
                        begin
                            pvalid_reg[ps_addr] <= 1'b1;
                            pdead_reg[ps_addr]  <= 1'b0;
                        end
                        else
                            time_reg <= time_next;
                    end
                end
                S_DIV:
                begin
                    // dead check, size check, page number
                    if (pdead_reg[pidx])
                        result.status <= ST_DEAD;
                    else if (item_reg.address >= psz_cur)
                    begin
                        pdead_reg[pidx] <= 1'b1;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        page_reg <= page_calc;
                        idx_reg  <= '0;
                        rd_v_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    // one frame read a cycle, compare the previous one
                    if (32'(idx_reg) < 32'(FRAME_CNT))
                    begin
                        rd_f_reg <= FW'(idx_reg);
                        rd_v_reg <= 1'b1;
                        idx_reg  <= idx_reg + FC'(1);
                    end
                    if (rd_v_reg)
                    begin
                        if (fown_reg[rd_f_reg])
                        begin
                            if (!hit_reg && frd_reg.owner == item_reg.pid[3:0] &&
                                frd_reg.page == page_reg)
                            begin
                                hit_reg    <= 1'b1;
                                hit_f_reg  <= rd_f_reg;
                                hit_ld_reg <= frd_reg.load_t;
                            end
                            if (rd_f_reg == '0 ||
                                (alg_reg ? frd_reg.use_t : frd_reg.load_t) < best_reg)
                            begin
                                best_reg  <= alg_reg ? frd_reg.use_t : frd_reg.load_t;
                                vic_f_reg <= rd_f_reg;
                                vpid_reg  <= frd_reg.owner;
                                vpage_reg <= frd_reg.page;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_reg   <= 1'b1;
                            free_f_reg <= rd_f_reg;
                        end
                    end
                end
                S_KILL:
                begin
                    // sweep frames and free those of the pid
                    if (32'(idx_reg) < 32'(FRAME_CNT))
                    begin
                        rd_f_reg <= FW'(idx_reg);
                        idx_reg  <= idx_reg + FC'(1);
                    end
                    if (idx_reg != '0 && frd_reg.owner == item_reg.pid[3:0])
                        fown_reg[rd_f_reg] <= 1'b0;
                    if (32'(idx_reg) == 32'(FRAME_CNT))
                        result.status <= ST_SEGFAULT;
                end
                S_WRITE:
                begin
                    if (hit_reg)
                    begin
                        result.status <= ST_HIT;
                        result.frame  <= 3'(hit_f_reg);
                    end
                    else
                    begin
                        fown_reg[fm_waddr] <= 1'b1;
                        result.frame <= 3'(fm_waddr);
                        if (free_reg)
                            result.status <= ST_FAULT;
                        else
                        begin
                            result.status      <= ST_EVICT;
                            result.evict_pid   <= vpid_reg;
                            result.victim_page <= 4'(vpage_reg);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/prfl_checker.sv @@
// ----------------------------------------------------------------------------
// prfl_checker
// Port-level checks of the paging frame manager.
// ----------------------------------------------------------------------------
`default_nettype none
module prfl_checker
    import prfl_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire prfl_out_t result
);

    // status codes stay in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_RECORDED) else $error("bad status");

    // evict_pid is zero unless the result is an eviction
    a_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_EVICT) |-> result.evict_pid == 4'd0)
        else $error("victim outside eviction");

    // a busy transfer ends with a result
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy fell without result");

    // done falls after each result unless start is high alongside it
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done || $past(start)) else $error("done held");

endmodule

bind page_replacement_fifo_lru prfl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .result(result)
);
`default_nettype wire
